@@ rtl/core/lcvp_pkg.sv @@
// Shared constants for the line clip and viewport projection block.
// Register indexes, clip codes, fixed-point limits and reset values.
// No dependencies.
package lcvp_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int COEF_WIDTH_DEF  = 16;

   localparam int ROW_W       = 64;
   localparam int FIELD_W     = 16;
   localparam int VP_W        = 14;
   localparam int ORG_W       = 13;
   localparam int CSR_INDEX_W = 8;
   localparam int CLIP_SAT_W  = 64;   // clip sums saturate to this signed range
   localparam int OFFSET_BITS = 30;   // bits spanned by viewport center plus origin
   localparam int DOT_LAT     = 4;

   localparam int POINT_EPS  = 1678;
   localparam int LINE_EPS   = 16777;
   localparam int SIZE_SHIFT = 15;
   localparam int ORG_SHIFT  = 16;
   localparam int ONE_SHIFT  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_ROW0  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW1  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW2  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW3  = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_VP_W  = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_VP_H  = 8'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ORG_X = 8'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_ORG_Y = 8'd7;

   localparam logic [1:0] CLIP_NONE = 2'd0;
   localparam logic [1:0] CLIP_A    = 2'd1;
   localparam logic [1:0] CLIP_B    = 2'd2;

   localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_0100;
   localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_0100_0000;
   localparam logic [ROW_W-1:0] ROW3_RST = 64'h0100_0000_0000_0000;
   localparam logic [VP_W-1:0]  VP_W_RST = 14'd1024;
   localparam logic [VP_W-1:0]  VP_H_RST = 14'd768;

endpackage

@@ rtl/core/lcvp_dot.sv @@
// One matrix-row lane: dot product of a point (implied w of 1) with one row.
// Products in one stage, then three saturating adds. Uses lcvp_pkg.
module lcvp_dot #(
   parameter int COORD_WIDTH = lcvp_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = lcvp_pkg::COEF_WIDTH_DEF,
   parameter int CLIP_WIDTH  = 50
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [COORD_WIDTH-1:0] px,
   input  logic signed [COORD_WIDTH-1:0] py,
   input  logic signed [COORD_WIDTH-1:0] pz,
   input  logic [lcvp_pkg::ROW_W-1:0]    row,
   output logic signed [CLIP_WIDTH-1:0]  clip
);

   localparam int PW = COORD_WIDTH + COEF_WIDTH;
   localparam int EW = CLIP_WIDTH + 1;
   localparam logic signed [EW-1:0] MAXC = EW'({1'b0, {(CLIP_WIDTH-1){1'b1}}});
   localparam logic signed [EW-1:0] MINC = ~MAXC;

   function automatic logic signed [CLIP_WIDTH-1:0] sat_add(
      input logic signed [CLIP_WIDTH-1:0] a,
      input logic signed [PW-1:0]         b);
      logic signed [EW-1:0] s;
      s = EW'(a) + EW'(b);
      if (s > MAXC) return MAXC[CLIP_WIDTH-1:0];
      else if (s < MINC) return MINC[CLIP_WIDTH-1:0];
      else return s[CLIP_WIDTH-1:0];
   endfunction

   logic signed [COEF_WIDTH-1:0] c0, c1, c2, c3;
   logic signed [PW-1:0]         p0_in, p1_in, p2_in;
   logic signed [CLIP_WIDTH-1:0] bias_in;

   logic signed [PW-1:0]         p0_ff, p1_ff, p2_ff, q1_ff, q2_ff, r2_ff;
   logic signed [CLIP_WIDTH-1:0] bias_ff, a2_ff, a3_ff, a4_ff;

   assign c0 = row[0 +: COEF_WIDTH];
   assign c1 = row[lcvp_pkg::FIELD_W +: COEF_WIDTH];
   assign c2 = row[2*lcvp_pkg::FIELD_W +: COEF_WIDTH];
   assign c3 = row[3*lcvp_pkg::FIELD_W +: COEF_WIDTH];

   assign p0_in   = PW'(px) * PW'(c0);
   assign p1_in   = PW'(py) * PW'(c1);
   assign p2_in   = PW'(pz) * PW'(c2);
   assign bias_in = CLIP_WIDTH'(c3) <<< lcvp_pkg::ONE_SHIFT;

   // accumulate bias, then the x, y and z products, saturating after every add
   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff   <= p0_in;
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         bias_ff <= bias_in;
         a2_ff   <= sat_add(bias_ff, p0_ff);
         q1_ff   <= p1_ff;
         q2_ff   <= p2_ff;
         a3_ff   <= sat_add(a2_ff, q1_ff);
         r2_ff   <= q2_ff;
         a4_ff   <= sat_add(a3_ff, r2_ff);
      end
   end

   assign clip = a4_ff;

endmodule

@@ rtl/core/lcvp_clip_div.sv @@
// Clip interpolation lane: base +/- floor(diff * num / den) with num <= den.
// One bit of diff per stage, remainder kept below den. Uses no package items.
module lcvp_clip_div #(
   parameter int CLIP_WIDTH = 50
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [CLIP_WIDTH-1:0] base,
   input  logic                         up,
   input  logic [CLIP_WIDTH:0]          diff,
   input  logic [CLIP_WIDTH:0]          num,
   input  logic [CLIP_WIDTH:0]          den,
   output logic signed [CLIP_WIDTH-1:0] result
);

   localparam int DW = CLIP_WIDTH + 1;

   logic [DW-1:0]         r_ff    [0:DW];
   logic [DW-1:0]         q_ff    [0:DW];
   logic [DW-1:0]         diff_ff [0:DW];
   logic [DW-1:0]         num_ff  [0:DW];
   logic [DW-1:0]         den_ff  [0:DW];
   logic signed [CLIP_WIDTH-1:0] base_ff [0:DW];
   logic                  up_ff   [0:DW];
   logic signed [CLIP_WIDTH-1:0] result_ff;

   logic [DW-1:0] r_in [1:DW];
   logic [DW-1:0] q_in [1:DW];
   logic [DW-1:0] sum_in;

   always_comb begin
      logic [DW+1:0] acc;
      logic [DW+1:0] d1;
      logic [DW+1:0] d2;
      logic [1:0]    inc;
      for (int k = 1; k <= DW; k++) begin
         acc = {1'b0, r_ff[k-1], 1'b0} +
               (diff_ff[k-1][DW-k] ? {2'b00, num_ff[k-1]} : {(DW+2){1'b0}});
         d1  = {2'b00, den_ff[k-1]};
         d2  = {1'b0, den_ff[k-1], 1'b0};
         if (acc >= d2) begin
            acc = acc - d2;
            inc = 2'd2;
         end else if (acc >= d1) begin
            acc = acc - d1;
            inc = 2'd1;
         end else begin
            inc = 2'd0;
         end
         r_in[k] = acc[DW-1:0];
         q_in[k] = {q_ff[k-1][DW-2:0], 1'b0} + DW'(inc);
      end
   end

   assign sum_in = up_ff[DW] ? ({base_ff[DW][CLIP_WIDTH-1], base_ff[DW]} + q_ff[DW])
                             : ({base_ff[DW][CLIP_WIDTH-1], base_ff[DW]} - q_ff[DW]);

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]    <= '0;
         q_ff[0]    <= '0;
         diff_ff[0] <= diff;
         num_ff[0]  <= num;
         den_ff[0]  <= den;
         base_ff[0] <= base;
         up_ff[0]   <= up;
         for (int k = 1; k <= DW; k++) begin
            r_ff[k]    <= r_in[k];
            q_ff[k]    <= q_in[k];
            diff_ff[k] <= diff_ff[k-1];
            num_ff[k]  <= num_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            base_ff[k] <= base_ff[k-1];
            up_ff[k]   <= up_ff[k-1];
         end
         result_ff <= sum_in[CLIP_WIDTH-1:0];
      end
   end

   assign result = result_ff;

endmodule

@@ rtl/core/lcvp_proj_div.sv @@
// Projection lane: floor(|v| * size * 2^15 / w), one quotient bit per stage.
// Flags quotients past the saturation point. Uses lcvp_pkg.
module lcvp_proj_div #(
   parameter int CLIP_WIDTH = 50,
   parameter int QUOT_WIDTH = 33
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [CLIP_WIDTH-1:0]  v,
   input  logic [lcvp_pkg::VP_W-1:0]     size,
   input  logic signed [CLIP_WIDTH-1:0]  w,
   output logic [QUOT_WIDTH:0]           mag_q,
   output logic                          neg
);

   localparam int QB   = QUOT_WIDTH;
   localparam int PRW  = CLIP_WIDTH + lcvp_pkg::VP_W;
   localparam int NW   = PRW + lcvp_pkg::SIZE_SHIFT;
   localparam int HW   = NW - QB;
   localparam int CMPW = (HW > CLIP_WIDTH) ? HW : CLIP_WIDTH;

   logic [CLIP_WIDTH-1:0] vmag;
   logic [PRW-1:0]        prod_in;
   logic [NW-1:0]         nfull;
   logic [CMPW-1:0]       hi_ext;
   logic [CMPW-1:0]       w_ext;

   logic [PRW-1:0]        prod_ff;
   logic                  neg_a_ff;
   logic [CLIP_WIDTH-1:0] w_a_ff;

   logic [CLIP_WIDTH-1:0] rem_ff [0:QB];
   logic [QB-1:0]         q_ff   [0:QB];
   logic [QB-1:0]         lo_ff  [0:QB];
   logic [CLIP_WIDTH-1:0] w_ff   [0:QB];
   logic                  neg_ff [0:QB];
   logic                  ovf_ff [0:QB];

   logic [CLIP_WIDTH-1:0] rem_in [1:QB];
   logic [QB-1:0]         q_in   [1:QB];

   assign vmag    = v[CLIP_WIDTH-1] ? (~v + 1'b1) : v;
   assign prod_in = PRW'(vmag) * PRW'(size);
   assign nfull   = {prod_ff, {lcvp_pkg::SIZE_SHIFT{1'b0}}};
   assign hi_ext  = CMPW'(nfull[NW-1:QB]);
   assign w_ext   = CMPW'(w_a_ff);

   always_comb begin
      logic [CLIP_WIDTH:0] t;
      logic                bit_q;
      for (int k = 1; k <= QB; k++) begin
         t = {rem_ff[k-1], lo_ff[k-1][QB-k]};
         if (t >= {1'b0, w_ff[k-1]}) begin
            t     = t - {1'b0, w_ff[k-1]};
            bit_q = 1'b1;
         end else begin
            bit_q = 1'b0;
         end
         rem_in[k] = t[CLIP_WIDTH-1:0];
         q_in[k]   = {q_ff[k-1][QB-2:0], bit_q};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= prod_in;
         neg_a_ff  <= v[CLIP_WIDTH-1];
         w_a_ff    <= w;
         // quotient of QB bits would overflow: mark as saturated
         ovf_ff[0] <= (hi_ext >= w_ext);
         rem_ff[0] <= hi_ext[CLIP_WIDTH-1:0];
         q_ff[0]   <= '0;
         lo_ff[0]  <= nfull[QB-1:0];
         w_ff[0]   <= w_a_ff;
         neg_ff[0] <= neg_a_ff;
         for (int k = 1; k <= QB; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            lo_ff[k]  <= lo_ff[k-1];
            w_ff[k]   <= w_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign mag_q = ovf_ff[QB] ? ((QB+1)'(1) << QB) : {1'b0, q_ff[QB]};
   assign neg   = neg_ff[QB];

endmodule

@@ rtl/core/line_clip_and_viewport_projection_top.sv @@
// Clip width CLW = min(COORD+COEF+2, 64), quotient width QB = max(COORD, 30) + 1.
// Throughput: one request per cycle; the whole pipeline holds while the
// response register is full and rsp_ready is low.
// Reset (synchronous): pipeline emptied, matrix set to identity, viewport
// 1024x768, origin 0. Configuration writes are taken every cycle.
module line_clip_and_viewport_projection_top #(
   parameter int COORD_WIDTH = lcvp_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = lcvp_pkg::COEF_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_command,
   input  logic signed [COORD_WIDTH-1:0]         req_ax,
   input  logic signed [COORD_WIDTH-1:0]         req_ay,
   input  logic signed [COORD_WIDTH-1:0]         req_az,
   input  logic signed [COORD_WIDTH-1:0]         req_bx,
   input  logic signed [COORD_WIDTH-1:0]         req_by,
   input  logic signed [COORD_WIDTH-1:0]         req_bz,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_visible,
   output logic [1:0]                            rsp_clipped_end,
   output logic signed [COORD_WIDTH-1:0]         rsp_x0,
   output logic signed [COORD_WIDTH-1:0]         rsp_y0,
   output logic signed [COORD_WIDTH-1:0]         rsp_x1,
   output logic signed [COORD_WIDTH-1:0]         rsp_y1,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lcvp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lcvp_pkg::ROW_W-1:0]            csr_data
);

   localparam int PW  = COORD_WIDTH + COEF_WIDTH;
   localparam int SW  = PW + 2;
   localparam int CLW = (SW > lcvp_pkg::CLIP_SAT_W) ? lcvp_pkg::CLIP_SAT_W : SW;
   localparam int DW  = CLW + 1;
   localparam int QB  = ((COORD_WIDTH > lcvp_pkg::OFFSET_BITS) ? COORD_WIDTH
                         : lcvp_pkg::OFFSET_BITS) + 1;
   localparam int CLIP_LAT = DW + 2;
   localparam int PROJ_LAT = QB + 2;
   localparam int SUMW     = QB + 3;
   localparam logic signed [SUMW-1:0] OMAX = SUMW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [SUMW-1:0] OMIN = ~OMAX;

   typedef struct packed {
      logic                  valid;
      logic                  cmd;
      logic                  vis;
      logic [1:0]            clipped;
      logic signed [CLW-1:0] wa;
      logic signed [CLW-1:0] wb;
   } clip_ctrl_type;

   typedef struct packed {
      logic       valid;
      logic       cmd;
      logic       vis;
      logic [1:0] clipped;
   } proj_ctrl_type;

   function automatic logic [COORD_WIDTH-1:0] clamp_out(input logic signed [SUMW-1:0] s);
      if (s > OMAX) return OMAX[COORD_WIDTH-1:0];
      else if (s < OMIN) return OMIN[COORD_WIDTH-1:0];
      else return s[COORD_WIDTH-1:0];
   endfunction

   // configuration
   logic [lcvp_pkg::ROW_W-1:0] row0_ff, row1_ff, row3_ff;
   logic [lcvp_pkg::VP_W-1:0]  vp_w_ff, vp_h_ff;
   logic [lcvp_pkg::ORG_W-1:0] org_x_ff, org_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff  <= lcvp_pkg::ROW0_RST;
         row1_ff  <= lcvp_pkg::ROW1_RST;
         row3_ff  <= lcvp_pkg::ROW3_RST;
         vp_w_ff  <= lcvp_pkg::VP_W_RST;
         vp_h_ff  <= lcvp_pkg::VP_H_RST;
         org_x_ff <= '0;
         org_y_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            lcvp_pkg::REG_ROW0:  row0_ff  <= csr_data;
            lcvp_pkg::REG_ROW1:  row1_ff  <= csr_data;
            lcvp_pkg::REG_ROW2:  ;  // z row never reaches the window coordinates
            lcvp_pkg::REG_ROW3:  row3_ff  <= csr_data;
            lcvp_pkg::REG_VP_W:  vp_w_ff  <= csr_data[lcvp_pkg::VP_W-1:0];
            lcvp_pkg::REG_VP_H:  vp_h_ff  <= csr_data[lcvp_pkg::VP_W-1:0];
            lcvp_pkg::REG_ORG_X: org_x_ff <= csr_data[lcvp_pkg::ORG_W-1:0];
            lcvp_pkg::REG_ORG_Y: org_y_ff <= csr_data[lcvp_pkg::ORG_W-1:0];
            default: ;
         endcase
      end
   end

   // global advance: hold everything while the response waits
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // transform lanes
   logic signed [CLW-1:0] ca_x, ca_y, ca_w, cb_x, cb_y, cb_w;

   lcvp_dot #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .CLIP_WIDTH(CLW)) u_dot_ax (
      .clock(clock), .en(en), .px(req_ax), .py(req_ay), .pz(req_az), .row(row0_ff), .clip(ca_x));
   lcvp_dot #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .CLIP_WIDTH(CLW)) u_dot_ay (
      .clock(clock), .en(en), .px(req_ax), .py(req_ay), .pz(req_az), .row(row1_ff), .clip(ca_y));
   lcvp_dot #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .CLIP_WIDTH(CLW)) u_dot_aw (
      .clock(clock), .en(en), .px(req_ax), .py(req_ay), .pz(req_az), .row(row3_ff), .clip(ca_w));
   lcvp_dot #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .CLIP_WIDTH(CLW)) u_dot_bx (
      .clock(clock), .en(en), .px(req_bx), .py(req_by), .pz(req_bz), .row(row0_ff), .clip(cb_x));
   lcvp_dot #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .CLIP_WIDTH(CLW)) u_dot_by (
      .clock(clock), .en(en), .px(req_bx), .py(req_by), .pz(req_bz), .row(row1_ff), .clip(cb_y));
   lcvp_dot #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .CLIP_WIDTH(CLW)) u_dot_bw (
      .clock(clock), .en(en), .px(req_bx), .py(req_by), .pz(req_bz), .row(row3_ff), .clip(cb_w));

   logic d_valid_ff [0:lcvp_pkg::DOT_LAT-1];
   logic d_cmd_ff   [0:lcvp_pkg::DOT_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < lcvp_pkg::DOT_LAT; k++) d_valid_ff[k] <= 1'b0;
      end else if (en) begin
         d_valid_ff[0] <= req_valid;
         for (int k = 1; k < lcvp_pkg::DOT_LAT; k++) d_valid_ff[k] <= d_valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_cmd_ff[0] <= req_command;
         for (int k = 1; k < lcvp_pkg::DOT_LAT; k++) d_cmd_ff[k] <= d_cmd_ff[k-1];
      end
   end

   // near-limit decision and clip setup
   logic                  sel_cmd, a_hi, b_hi, sel_vis;
   logic [1:0]            sel_clip;
   logic signed [DW-1:0]  dx, dy;
   logic [DW-1:0]         dx_mag, dy_mag, num_a, den_a, num_b, den_b;
   clip_ctrl_type         ctrl_a_in;

   assign sel_cmd = d_cmd_ff[lcvp_pkg::DOT_LAT-1];
   assign a_hi    = ca_w > lcvp_pkg::LINE_EPS;
   assign b_hi    = cb_w > lcvp_pkg::LINE_EPS;
   assign sel_vis = sel_cmd ? (a_hi || b_hi) : (ca_w > lcvp_pkg::POINT_EPS);

   always_comb begin
      priority if (!sel_cmd || !sel_vis) sel_clip = lcvp_pkg::CLIP_NONE;
      else if (!a_hi)                    sel_clip = lcvp_pkg::CLIP_A;
      else if (!b_hi)                    sel_clip = lcvp_pkg::CLIP_B;
      else                               sel_clip = lcvp_pkg::CLIP_NONE;
   end

   assign dx     = DW'(cb_x) - DW'(ca_x);
   assign dy     = DW'(cb_y) - DW'(ca_y);
   assign dx_mag = dx[DW-1] ? DW'(-dx) : DW'(dx);
   assign dy_mag = dy[DW-1] ? DW'(-dy) : DW'(dy);

   // an end that stays put runs through its lane with a zero fraction
   assign num_a = (sel_clip == lcvp_pkg::CLIP_A) ? DW'(DW'(lcvp_pkg::LINE_EPS) - DW'(ca_w)) : '0;
   assign den_a = (sel_clip == lcvp_pkg::CLIP_A) ? DW'(DW'(cb_w) - DW'(ca_w)) : DW'(1);
   assign num_b = (sel_clip == lcvp_pkg::CLIP_B) ? DW'(DW'(lcvp_pkg::LINE_EPS) - DW'(cb_w)) : '0;
   assign den_b = (sel_clip == lcvp_pkg::CLIP_B) ? DW'(DW'(ca_w) - DW'(cb_w)) : DW'(1);

   always_comb begin
      ctrl_a_in.valid   = d_valid_ff[lcvp_pkg::DOT_LAT-1];
      ctrl_a_in.cmd     = sel_cmd;
      ctrl_a_in.vis     = sel_vis;
      ctrl_a_in.clipped = sel_clip;
      ctrl_a_in.wa      = (sel_clip == lcvp_pkg::CLIP_A) ? CLW'(lcvp_pkg::LINE_EPS) : ca_w;
      ctrl_a_in.wb      = (sel_clip == lcvp_pkg::CLIP_B) ? CLW'(lcvp_pkg::LINE_EPS) : cb_w;
   end

   logic signed [CLW-1:0] clx_a, cly_a, clx_b, cly_b;

   lcvp_clip_div #(.CLIP_WIDTH(CLW)) u_clip_ax (
      .clock(clock), .en(en), .base(ca_x), .up(!dx[DW-1]), .diff(dx_mag),
      .num(num_a), .den(den_a), .result(clx_a));
   lcvp_clip_div #(.CLIP_WIDTH(CLW)) u_clip_ay (
      .clock(clock), .en(en), .base(ca_y), .up(!dy[DW-1]), .diff(dy_mag),
      .num(num_a), .den(den_a), .result(cly_a));
   lcvp_clip_div #(.CLIP_WIDTH(CLW)) u_clip_bx (
      .clock(clock), .en(en), .base(cb_x), .up(dx[DW-1]), .diff(dx_mag),
      .num(num_b), .den(den_b), .result(clx_b));
   lcvp_clip_div #(.CLIP_WIDTH(CLW)) u_clip_by (
      .clock(clock), .en(en), .base(cb_y), .up(dy[DW-1]), .diff(dy_mag),
      .num(num_b), .den(den_b), .result(cly_b));

   clip_ctrl_type ctrl_a_ff [0:CLIP_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CLIP_LAT; k++) ctrl_a_ff[k].valid <= 1'b0;
      end else if (en) begin
         ctrl_a_ff[0] <= ctrl_a_in;
         for (int k = 1; k < CLIP_LAT; k++) ctrl_a_ff[k] <= ctrl_a_ff[k-1];
      end
   end

   // projection lanes
   clip_ctrl_type ctl_a;
   assign ctl_a = ctrl_a_ff[CLIP_LAT-1];

   logic [QB:0] t_x0, t_y0, t_x1, t_y1;
   logic        n_x0, n_y0, n_x1, n_y1;

   lcvp_proj_div #(.CLIP_WIDTH(CLW), .QUOT_WIDTH(QB)) u_proj_x0 (
      .clock(clock), .en(en), .v(clx_a), .size(vp_w_ff), .w(ctl_a.wa), .mag_q(t_x0), .neg(n_x0));
   lcvp_proj_div #(.CLIP_WIDTH(CLW), .QUOT_WIDTH(QB)) u_proj_y0 (
      .clock(clock), .en(en), .v(cly_a), .size(vp_h_ff), .w(ctl_a.wa), .mag_q(t_y0), .neg(n_y0));
   lcvp_proj_div #(.CLIP_WIDTH(CLW), .QUOT_WIDTH(QB)) u_proj_x1 (
      .clock(clock), .en(en), .v(clx_b), .size(vp_w_ff), .w(ctl_a.wb), .mag_q(t_x1), .neg(n_x1));
   lcvp_proj_div #(.CLIP_WIDTH(CLW), .QUOT_WIDTH(QB)) u_proj_y1 (
      .clock(clock), .en(en), .v(cly_b), .size(vp_h_ff), .w(ctl_a.wb), .mag_q(t_y1), .neg(n_y1));

   proj_ctrl_type ctrl_b_ff [0:PROJ_LAT-1];
   proj_ctrl_type ctrl_b_in;

   always_comb begin
      ctrl_b_in.valid   = ctl_a.valid;
      ctrl_b_in.cmd     = ctl_a.cmd;
      ctrl_b_in.vis     = ctl_a.vis;
      ctrl_b_in.clipped = ctl_a.clipped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PROJ_LAT; k++) ctrl_b_ff[k].valid <= 1'b0;
      end else if (en) begin
         ctrl_b_ff[0] <= ctrl_b_in;
         for (int k = 1; k < PROJ_LAT; k++) ctrl_b_ff[k] <= ctrl_b_ff[k-1];
      end
   end

   // merge: window offsets, y flip, saturation
   proj_ctrl_type          ctl_b;
   logic signed [SUMW-1:0] hx, hy, ox, oy, s_x0, s_y0, s_x1, s_y1;
   logic [COORD_WIDTH-1:0] x0_in, y0_in, x1_in, y1_in;

   assign ctl_b = ctrl_b_ff[PROJ_LAT-1];
   assign hx    = SUMW'(vp_w_ff) << lcvp_pkg::SIZE_SHIFT;
   assign hy    = SUMW'(vp_h_ff) << lcvp_pkg::SIZE_SHIFT;
   assign ox    = SUMW'(org_x_ff) << lcvp_pkg::ORG_SHIFT;
   assign oy    = SUMW'(org_y_ff) << lcvp_pkg::ORG_SHIFT;
   assign s_x0  = n_x0 ? -SUMW'(t_x0) : SUMW'(t_x0);
   assign s_y0  = n_y0 ? -SUMW'(t_y0) : SUMW'(t_y0);
   assign s_x1  = n_x1 ? -SUMW'(t_x1) : SUMW'(t_x1);
   assign s_y1  = n_y1 ? -SUMW'(t_y1) : SUMW'(t_y1);
   assign x0_in = clamp_out(s_x0 + hx + ox);
   assign y0_in = clamp_out(hy - s_y0 + oy);
   assign x1_in = clamp_out(s_x1 + hx + ox);
   assign y1_in = clamp_out(hy - s_y1 + oy);

   logic                   rsp_visible_ff;
   logic [1:0]             rsp_clipped_ff;
   logic [COORD_WIDTH-1:0] rsp_x0_ff, rsp_y0_ff, rsp_x1_ff, rsp_y1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ctl_b.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_visible_ff <= ctl_b.vis;
         rsp_clipped_ff <= ctl_b.clipped;
         rsp_x0_ff      <= ctl_b.vis ? x0_in : '0;
         rsp_y0_ff      <= ctl_b.vis ? y0_in : '0;
         rsp_x1_ff      <= (ctl_b.vis && ctl_b.cmd) ? x1_in : '0;
         rsp_y1_ff      <= (ctl_b.vis && ctl_b.cmd) ? y1_in : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_visible     = rsp_visible_ff;
   assign rsp_clipped_end = rsp_clipped_ff;
   assign rsp_x0          = rsp_x0_ff;
   assign rsp_y0          = rsp_y0_ff;
   assign rsp_x1          = rsp_x1_ff;
   assign rsp_y1          = rsp_y1_ff;

endmodule

@@ rtl/core/lcvp_checker.sv @@
// Port-level checks for the line clip and viewport projection top level.
// Bound to line_clip_and_viewport_projection_top; uses lcvp_pkg.
module lcvp_checker #(
   parameter int COORD_WIDTH = lcvp_pkg::COORD_WIDTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_visible,
   input logic [1:0]             rsp_clipped_end,
   input logic [COORD_WIDTH-1:0] rsp_x0,
   input logic [COORD_WIDTH-1:0] rsp_y0,
   input logic [COORD_WIDTH-1:0] rsp_x1,
   input logic [COORD_WIDTH-1:0] rsp_y1
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x0) && $stable(rsp_y0)
         && $stable(rsp_x1) && $stable(rsp_y1) && $stable(rsp_clipped_end))
      else $error("response changed while stalled");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_x0 == 0 && rsp_y0 == 0 && rsp_x1 == 0
         && rsp_y1 == 0 && rsp_clipped_end == lcvp_pkg::CLIP_NONE)
      else $error("hidden request carries nonzero fields");

   a_clip_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped_end != lcvp_pkg::CLIP_NONE |->
         rsp_visible && (rsp_clipped_end == lcvp_pkg::CLIP_A
                         || rsp_clipped_end == lcvp_pkg::CLIP_B))
      else $error("bad clipped end code");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline held");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind line_clip_and_viewport_projection_top lcvp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lcvp_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready), .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready), .rsp_visible(rsp_visible), .rsp_clipped_end(rsp_clipped_end),
   .rsp_x0(rsp_x0), .rsp_y0(rsp_y0), .rsp_x1(rsp_x1), .rsp_y1(rsp_y1));

@@ tb/sv/line_clip_and_viewport_projection_top_tb.sv @@
// Self-checking testbench for line_clip_and_viewport_projection_top.
// Depends on lcvp_pkg and the block itself; carries its own projection predictor.
`timescale 1ns / 1ps

module line_clip_and_viewport_projection_top_tb;
   import lcvp_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD = 400;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic          cmd;
      logic [CW-1:0] ax, ay, az, bx, by, bz;
   } seg_req_t;

   typedef struct {
      logic          vis;
      logic [1:0]    clip;
      logic [CW-1:0] x0, y0, x1, y1;
   } screen_rsp_t;

   typedef longint clip_vec_t [4];

   logic clock, reset;
   logic req_valid, req_ready, req_command;
   logic signed [CW-1:0] req_ax, req_ay, req_az, req_bx, req_by, req_bz;
   logic rsp_valid, rsp_ready, rsp_visible;
   logic [1:0] rsp_clipped_end;
   logic signed [CW-1:0] rsp_x0, rsp_y0, rsp_x1, rsp_y1;
   logic csr_valid, csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [ROW_W-1:0] csr_data;

   line_clip_and_viewport_projection_top dut (.*);

   // configuration mirror
   logic [ROW_W-1:0] mat [4];
   logic [VP_W-1:0]  vp_width, vp_height;
   logic [ORG_W-1:0] org_x, org_y;

   seg_req_t    pending_reqs [$];
   screen_rsp_t expected_rsps [$];
   int error_count, reqs_sent, rsps_checked, num_visible, num_clipped;
   int idle_cycles;
   bit req_taken;
   int burst_left, gap_left, gap_max, stall_pct;
   bit send_hold, hold_trigger, hold_done;
   int hold_left;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------- predictor ----------------
   function automatic logic [63:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] d);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      if (d == 0 || p[127:64] >= d) return '1;
      return 64'(p / {64'd0, d});
   endfunction

   function automatic longint coef(int r, int j);
      return longint'($signed(mat[r][16*j +: 16]));
   endfunction

   // clip sums stay far inside 64 bits at these widths, no saturation needed
   function automatic clip_vec_t to_clip(logic [CW-1:0] px, logic [CW-1:0] py,
                                         logic [CW-1:0] pz);
      clip_vec_t c;
      longint p [3];
      p[0] = longint'($signed(px));
      p[1] = longint'($signed(py));
      p[2] = longint'($signed(pz));
      for (int r = 0; r < 4; r++) begin
         c[r] = coef(r, 3) * 65536;
         for (int j = 0; j < 3; j++) c[r] += coef(r, j) * p[j];
      end
      return c;
   endfunction

   // slide end a toward b until its w sits exactly on the line limit
   function automatic clip_vec_t move_to_near(clip_vec_t a, clip_vec_t b);
      logic [63:0] num, den, diff, q;
      bit up;
      num = 64'(longint'(LINE_EPS)) - 64'(a[3]);
      den = 64'(b[3]) - 64'(a[3]);
      for (int k = 0; k < 3; k++) begin
         up = b[k] >= a[k];
         diff = up ? 64'(b[k]) - 64'(a[k]) : 64'(a[k]) - 64'(b[k]);
         q = mul_div(diff, num, den);
         a[k] = up ? longint'(64'(a[k]) + q) : longint'(64'(a[k]) - q);
      end
      a[3] = LINE_EPS;
      return a;
   endfunction

   function automatic longint clamp_coord(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic longint scale_axis(longint v, logic [63:0] size, longint w);
      logic [63:0] m, q;
      longint t;
      m = v < 0 ? -64'(v) : 64'(v);
      q = mul_div(m, size * 64'd32768, 64'(w));
      t = (q > (64'd1 << 62)) ? (longint'(1) <<< 62) : longint'(q);
      return v < 0 ? -t : t;
   endfunction

   function automatic void to_window(clip_vec_t c, output logic [CW-1:0] sx,
                                     output logic [CW-1:0] sy);
      longint hx, hy;
      hx = longint'(vp_width) * 32768;
      hy = longint'(vp_height) * 32768;
      sx = CW'(clamp_coord(scale_axis(c[0], 64'(vp_width), c[3]) + hx
                           + longint'(org_x) * 65536));
      sy = CW'(clamp_coord(hy - scale_axis(c[1], 64'(vp_height), c[3])
                           + longint'(org_y) * 65536));
   endfunction

   function automatic screen_rsp_t project_request(seg_req_t r);
      screen_rsp_t e;
      clip_vec_t ca, cb;
      e = '{default: '0};
      ca = to_clip(r.ax, r.ay, r.az);
      if (!r.cmd) begin
         if (ca[3] > POINT_EPS) begin
            e.vis = 1'b1;
            to_window(ca, e.x0, e.y0);
         end
      end else begin
         cb = to_clip(r.bx, r.by, r.bz);
         if (ca[3] > LINE_EPS || cb[3] > LINE_EPS) begin
            e.vis = 1'b1;
            if (ca[3] <= LINE_EPS) begin
               ca = move_to_near(ca, cb);
               e.clip = CLIP_A;
            end else if (cb[3] <= LINE_EPS) begin
               cb = move_to_near(cb, ca);
               e.clip = CLIP_B;
            end
            to_window(ca, e.x0, e.y0);
            to_window(cb, e.x1, e.y1);
         end
      end
      return e;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // ---------------- driver ----------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the request until it is taken
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0 && !send_hold) begin
         seg_req_t r;
         r = pending_reqs.pop_front();
         req_valid <= 1'b1;
         req_command <= r.cmd;
         req_ax <= r.ax; req_ay <= r.ay; req_az <= r.az;
         req_bx <= r.bx; req_by <= r.by; req_bz <= r.bz;
         if (burst_left == 0) begin
            burst_left <= $urandom_range(0, 20);
            gap_left <= gap_max > 0 ? $urandom_range(0, gap_max) : 0;
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver stall pattern, with one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_trigger && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(0, 99) >= stall_pct;
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (!reset) begin
         screen_rsp_t e;
         seg_req_t r;
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            r.cmd = req_command;
            r.ax = req_ax; r.ay = req_ay; r.az = req_az;
            r.bx = req_bx; r.by = req_by; r.bz = req_bz;
            expected_rsps.push_back(project_request(r));
            reqs_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("[%0t] response with nothing outstanding", $realtime);
               error_count++;
            end else begin
               e = expected_rsps.pop_front();
               rsps_checked++;
               if (e.vis) num_visible++;
               if (e.clip != CLIP_NONE) num_clipped++;
               if (rsp_visible !== e.vis) report("visible", rsp_visible, e.vis);
               if (rsp_clipped_end !== e.clip) report("clipped_end", rsp_clipped_end, e.clip);
               if (rsp_x0 !== e.x0) report("x0", rsp_x0, e.x0);
               if (rsp_y0 !== e.y0) report("y0", rsp_y0, e.y0);
               if (rsp_x1 !== e.x1) report("x1", rsp_x1, e.x1);
               if (rsp_y1 !== e.y1) report("y1", rsp_y1, e.y1);
            end
         end
         if (req_taken || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d responses outstanding", expected_rsps.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [ROW_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: mat[idx] = val;
         REG_VP_W:  vp_width = val[VP_W-1:0];
         REG_VP_H:  vp_height = val[VP_W-1:0];
         REG_ORG_X: org_x = val[ORG_W-1:0];
         REG_ORG_Y: org_y = val[ORG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_release();
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2, 3, 4: return CW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         5, 6: return CW'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
         default: return CW'($signed($urandom_range(0, 8192)) - 4096);
      endcase
   endfunction

   function automatic seg_req_t rand_req();
      seg_req_t r;
      r.cmd = $urandom_range(0, 2) != 0;
      r.ax = rand_coord(); r.ay = rand_coord(); r.az = rand_coord();
      r.bx = rand_coord(); r.by = rand_coord(); r.bz = rand_coord();
      return r;
   endfunction

   function automatic logic [15:0] rand_coef(bit wide);
      return wide ? 16'($urandom) : 16'($signed($urandom_range(0, 1024)) - 512);
   endfunction

   function automatic seg_req_t mk(logic c, longint ax, longint ay, longint az,
                                   longint bx, longint by, longint bz);
      seg_req_t r;
      r.cmd = c;
      r.ax = CW'(ax); r.ay = CW'(ay); r.az = CW'(az);
      r.bx = CW'(bx); r.by = CW'(by); r.bz = CW'(bz);
      return r;
   endfunction

   initial begin
      logic [ROW_W-1:0] row;
      bit wide;
      longint smax, smin;
      smax = 64'sh7FFF_FFFF;
      smin = -64'sh8000_0000;
      reset = 1'b1;
      req_valid = 1'b0; req_command = 1'b0;
      req_ax = '0; req_ay = '0; req_az = '0; req_bx = '0; req_by = '0; req_bz = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      burst_left = 0; gap_left = 0; gap_max = 4; stall_pct = 20;
      send_hold = 0; hold_trigger = 0; hold_done = 0; hold_left = 0;
      error_count = 0; reqs_sent = 0; rsps_checked = 0; num_visible = 0;
      num_clipped = 0; idle_cycles = 0; req_taken = 0;
      mat[0] = ROW0_RST; mat[1] = ROW1_RST; mat[2] = 64'h0000_0100_0000_0000;
      mat[3] = ROW3_RST;
      vp_width = VP_W_RST; vp_height = VP_H_RST; org_x = '0; org_y = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset identity: w is always one
      for (int i = 0; i < 150; i++) pending_reqs.push_back(rand_req());
      wait_drained();

      // w equals world z so the near limits land on plain integers
      csr_write(REG_ROW3, 64'h0000_0001_0000_0000);
      csr_release();
      pending_reqs.push_back(mk(0, 100, 200, POINT_EPS, 0, 0, 0));
      pending_reqs.push_back(mk(0, smax, smin, POINT_EPS + 1, smax, smax, smax));
      pending_reqs.push_back(mk(0, smin, smax, smax, smin, smin, smin));
      pending_reqs.push_back(mk(0, 5, 5, -5, 0, 0, 0));
      pending_reqs.push_back(mk(0, smin, smin, smin, 0, 0, 0));
      pending_reqs.push_back(mk(1, 1, 2, LINE_EPS, 3, 4, LINE_EPS));
      pending_reqs.push_back(mk(1, 1, 2, -9000, 3, 4, smin));
      pending_reqs.push_back(mk(1, -700, 900, LINE_EPS, 7000, -3000, LINE_EPS + 1));
      pending_reqs.push_back(mk(1, 7000, -3000, 100000, -700, 900, LINE_EPS));
      pending_reqs.push_back(mk(1, smax, smin, 200000, smin, smax, -200000));
      pending_reqs.push_back(mk(1, smin, smax, -200000, smax, smin, 200000));
      pending_reqs.push_back(mk(1, smax, smax, smax, smin, smin, smax));
      pending_reqs.push_back(mk(1, smin, smin, smax, smax, smax, LINE_EPS + 1));
      pending_reqs.push_back(mk(1, 0, 0, 20000, 0, 0, 30000));
      pending_reqs.push_back(mk(1, 12345, -54321, smin, -1, 1, smax));
      pending_reqs.push_back(mk(0, -1, -1, -1, -1, -1, -1));
      pending_reqs.push_back(mk(1, -1, -1, -1, -1, -1, -1));
      pending_reqs.push_back(mk(0, 3000, -3000, 1 << 20, 0, 0, 0));
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         wide = ph == 4;
         for (int r = 0; r < 3; r++) begin
            row = {rand_coef(wide), rand_coef(wide), rand_coef(wide), rand_coef(wide)};
            csr_write(r[CSR_INDEX_W-1:0] == 0 ? REG_ROW0 : (r == 1 ? REG_ROW1 : REG_ROW2),
                      row);
         end
         // perspective row: small bias with random x, y and z weights so ends straddle the near limits
         row = {16'($signed($urandom_range(0, 64)) - 32), rand_coef(wide),
                rand_coef(wide), rand_coef(wide)};
         csr_write(REG_ROW3, ph == 5 ? {$urandom, $urandom} : row);
         case (ph)
            0: begin csr_write(REG_VP_W, 64'd1);    csr_write(REG_VP_H, 64'd8192); end
            1: begin csr_write(REG_VP_W, 64'd8192); csr_write(REG_VP_H, 64'd1);    end
            2: begin csr_write(REG_VP_W, 64'h4000); csr_write(REG_VP_H, 64'h3FFF); end
            default: begin
               csr_write(REG_VP_W, {$urandom, $urandom});
               csr_write(REG_VP_H, 64'($urandom_range(1, 8192)));
            end
         endcase
         csr_write(REG_ORG_X, ph[0] ? 64'd8191 : {$urandom, $urandom});
         csr_write(REG_ORG_Y, ph[0] ? 64'd0 : 64'd8191);
         csr_write(CSR_INDEX_W'($urandom_range(8, 255)), {$urandom, $urandom});
         csr_release();
         stall_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1 ? 30 : 75);
         gap_max = (ph == 1) ? 0 : 6;
         if (ph == 2) hold_trigger = 1'b1;
         for (int i = 0; i < 300; i++) pending_reqs.push_back(rand_req());
         if (ph == 3) begin
            while (pending_reqs.size() > 150) @(posedge clock);
            // pause the sender until the pipeline has emptied
            send_hold = 1'b1;
            while (req_valid || expected_rsps.size() > 0) @(posedge clock);
            send_hold = 1'b0;
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests under 8 register settings, %0d responses checked",
               reqs_sent, rsps_checked);
      $display("%0d drawn, %0d with a moved end, %0d mismatches",
               num_visible, num_clipped, error_count);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
